// File: hw/rtl/dbcg_pkg.sv
// dbcg_pkg: shared types, constants and helper functions of the backlight dimming core
// no dependencies; used by dbcg_cfg, dbcg_ctrl, dbcg_dpath and the top level
package dbcg_pkg;

    // default sizes
    localparam int TABLE_ENTRIES_DEF = 66;
    localparam int LEVEL_BITS_DEF    = 12;

    // fixed field widths
    localparam int THRESH_BITS = 12;
    localparam int GAIN_BITS   = 16;
    localparam int DEPTH_BITS  = 4;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;

    // gain rom geometry
    localparam int ROM_LEN   = 66;
    localparam int ROM_AW    = 8;
    localparam int ROM_DW    = 9;
    localparam int ROM_SHIFT = 7;
    localparam int MAX_DEPTH = 8;
    localparam int GAIN_UNIT = 128;

    // register reset values and threshold floor
    localparam logic [THRESH_BITS-1:0] THRESH_MIN   = 12'd2;
    localparam logic [THRESH_BITS-1:0] THRESH_RST   = 12'd66;
    localparam logic [GAIN_BITS-1:0]   MIN_GAIN_RST = 16'd5120;
    localparam logic [GAIN_BITS-1:0]   MAX_GAIN_RST = 16'd32768;

    // register map, word index
    typedef enum logic [1:0] {
        REG_MODE     = 2'd0,
        REG_THRESH   = 2'd1,
        REG_MIN_GAIN = 2'd2,
        REG_MAX_GAIN = 2'd3
    } reg_idx_t;

    // what a request turns into
    typedef enum logic [1:0] {
        CLS_PASS  = 2'd0,
        CLS_DIM   = 2'd1,
        CLS_LEAVE = 2'd2
    } cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_DIV,
        ST_GAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                   mode_enable;
        logic [THRESH_BITS-1:0] thresh;
        logic [GAIN_BITS-1:0]   min_gain;
        logic [GAIN_BITS-1:0]   max_gain;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic gain_load;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        cls_t cls;
    } sts_t;

    // gain rom, addresses past the end read the last entry
    function automatic logic [ROM_DW-1:0] rom_read(input logic [ROM_AW-1:0] addr);
        logic [ROM_DW-1:0] v;
        case (addr)
            8'd0:  v = 9'd42;   8'd1:  v = 9'd56;   8'd2:  v = 9'd67;   8'd3:  v = 9'd75;
            8'd4:  v = 9'd84;   8'd5:  v = 9'd91;   8'd6:  v = 9'd98;   8'd7:  v = 9'd104;
            8'd8:  v = 9'd109;  8'd9:  v = 9'd114;  8'd10: v = 9'd119;  8'd11: v = 9'd124;
            8'd12: v = 9'd128;  8'd13: v = 9'd133;  8'd14: v = 9'd136;  8'd15: v = 9'd140;
            8'd16: v = 9'd143;  8'd17: v = 9'd146;  8'd18: v = 9'd150;  8'd19: v = 9'd152;
            8'd20: v = 9'd156;  8'd21: v = 9'd159;  8'd22: v = 9'd162;  8'd23: v = 9'd165;
            8'd24: v = 9'd168;  8'd25: v = 9'd172;  8'd26: v = 9'd176;  8'd27: v = 9'd178;
            8'd28: v = 9'd181;  8'd29: v = 9'd184;  8'd30: v = 9'd187;  8'd31: v = 9'd189;
            8'd32: v = 9'd192;  8'd33: v = 9'd194;  8'd34: v = 9'd196;  8'd35: v = 9'd199;
            8'd36: v = 9'd202;  8'd37: v = 9'd204;  8'd38: v = 9'd206;  8'd39: v = 9'd209;
            8'd40: v = 9'd211;  8'd41: v = 9'd213;  8'd42: v = 9'd215;  8'd43: v = 9'd217;
            8'd44: v = 9'd220;  8'd45: v = 9'd222;  8'd46: v = 9'd224;  8'd47: v = 9'd226;
            8'd48: v = 9'd228;  8'd49: v = 9'd230;  8'd50: v = 9'd233;  8'd51: v = 9'd236;
            8'd52: v = 9'd237;  8'd53: v = 9'd239;  8'd54: v = 9'd241;  8'd55: v = 9'd241;
            8'd56: v = 9'd243;  8'd57: v = 9'd245;  8'd58: v = 9'd246;  8'd59: v = 9'd249;
            8'd60: v = 9'd249;  8'd61: v = 9'd250;  8'd62: v = 9'd252;  8'd63: v = 9'd254;
            8'd64: v = 9'd255;
            default: v = 9'd256;
        endcase
        return v;
    endfunction

    // largest depth d with gain >= 128 << d, zero if none
    function automatic logic [DEPTH_BITS-1:0] depth_of(input logic [GAIN_BITS-1:0] g);
        logic [DEPTH_BITS-1:0] res;
        res = '0;
        for (int d = 1; d <= MAX_DEPTH; d++) begin
            if ({1'b0, g} >= ((GAIN_BITS+1)'(GAIN_UNIT) << d)) begin
                res = DEPTH_BITS'(d);
            end
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/dbcg_cfg.sv
// dbcg_cfg: apb-style configuration registers of the backlight dimming core
// depends on dbcg_pkg
module dbcg_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dbcg_pkg::ADDR_BITS-1:0] paddr,
    input  logic [dbcg_pkg::DATA_BITS-1:0] pwdata,
    output logic [dbcg_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output dbcg_pkg::cfg_t                 cfg
);

    dbcg_pkg::cfg_t      cfg_reg;
    dbcg_pkg::cfg_t      cfg_next;
    dbcg_pkg::reg_idx_t  idx;
    logic                wr_en;

    assign idx    = dbcg_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                dbcg_pkg::REG_MODE:     cfg_next.mode_enable = pwdata[0];
                dbcg_pkg::REG_THRESH:   cfg_next.thresh = pwdata[dbcg_pkg::THRESH_BITS-1:0];
                dbcg_pkg::REG_MIN_GAIN: cfg_next.min_gain = pwdata[dbcg_pkg::GAIN_BITS-1:0];
                dbcg_pkg::REG_MAX_GAIN: cfg_next.max_gain = pwdata[dbcg_pkg::GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode_enable <= 1'b0;
            cfg_reg.thresh      <= dbcg_pkg::THRESH_RST;
            cfg_reg.min_gain    <= dbcg_pkg::MIN_GAIN_RST;
            cfg_reg.max_gain    <= dbcg_pkg::MAX_GAIN_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // read back
    always_comb begin
        case (idx)
            dbcg_pkg::REG_MODE:     prdata = dbcg_pkg::DATA_BITS'(cfg_reg.mode_enable);
            dbcg_pkg::REG_THRESH:   prdata = dbcg_pkg::DATA_BITS'(cfg_reg.thresh);
            dbcg_pkg::REG_MIN_GAIN: prdata = dbcg_pkg::DATA_BITS'(cfg_reg.min_gain);
            dbcg_pkg::REG_MAX_GAIN: prdata = dbcg_pkg::DATA_BITS'(cfg_reg.max_gain);
            default:                prdata = '0;
        endcase
    end

endmodule

// File: hw/rtl/dbcg_ctrl.sv
// dbcg_ctrl: sequencer of the backlight dimming core, drives the datapath by commands
// depends on dbcg_pkg
module dbcg_ctrl #(
    parameter int QBITS = 7
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  dbcg_pkg::sts_t sts,
    output dbcg_pkg::cmd_t cmd
);

    localparam int CNT_W = (QBITS > 1) ? $clog2(QBITS) : 1;

    dbcg_pkg::state_t  state_reg;
    dbcg_pkg::state_t  state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dbcg_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            dbcg_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = dbcg_pkg::ST_DECIDE;
                end
            end
            dbcg_pkg::ST_DECIDE: begin
                case (sts.cls)
                    dbcg_pkg::CLS_DIM:   state_next = dbcg_pkg::ST_MUL;
                    dbcg_pkg::CLS_LEAVE: state_next = dbcg_pkg::ST_GAIN;
                    default:             state_next = dbcg_pkg::ST_DONE;
                endcase
            end
            dbcg_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                cnt_next   = CNT_W'(QBITS - 1);
                state_next = dbcg_pkg::ST_DIV;
            end
            dbcg_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = dbcg_pkg::ST_GAIN;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            dbcg_pkg::ST_GAIN: begin
                cmd.gain_load = 1'b1;
                state_next    = dbcg_pkg::ST_DONE;
            end
            dbcg_pkg::ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = dbcg_pkg::ST_IDLE;
                end
            end
            default: state_next = dbcg_pkg::ST_IDLE;
        endcase
    end

    // output register occupancy
    assign out_valid_next = cmd.out_load ? 1'b1 : (out_valid_reg && !m_ready);
    assign m_valid        = out_valid_reg;

endmodule

// File: hw/rtl/dbcg_dpath.sv
// dbcg_dpath: datapath of the backlight dimming core: classify, scale, divide, gain, output
// depends on dbcg_pkg
module dbcg_dpath #(
    parameter int TABLE_ENTRIES = 66,
    parameter int LEVEL_BITS    = 12,
    parameter int QBITS         = 7
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dbcg_pkg::cfg_t                    cfg,
    input  dbcg_pkg::cmd_t                    cmd,
    output dbcg_pkg::sts_t                    sts,
    input  logic [LEVEL_BITS-1:0]             s_level,
    output logic [dbcg_pkg::THRESH_BITS-1:0]  m_panel_level,
    output logic                              m_gain_write,
    output logic                              m_gain_enable,
    output logic [dbcg_pkg::GAIN_BITS-1:0]    m_gain_value,
    output logic                              m_dither_enable,
    output logic [dbcg_pkg::DEPTH_BITS-1:0]   m_dither_depth
);

    localparam int TW     = dbcg_pkg::THRESH_BITS;
    localparam int CW     = (LEVEL_BITS > TW) ? LEVEL_BITS : TW;
    localparam int PROD_W = TW + QBITS;
    localparam int GW     = dbcg_pkg::GAIN_BITS;
    localparam int LAST_ADDR = ((TABLE_ENTRIES < dbcg_pkg::ROM_LEN) ?
                                TABLE_ENTRIES : dbcg_pkg::ROM_LEN) - 1;

    logic                    dim_active_reg;
    dbcg_pkg::cls_t          cls_reg;
    dbcg_pkg::cls_t          cls_next;
    logic [TW-1:0]           thr_eff;
    logic [CW-1:0]           lvl_ext;
    logic                    lvl_nz;
    logic                    lvl_lt;
    logic [TW-1:0]           panel_reg;
    logic [TW-1:0]           num_reg;
    logic                    mode_reg;
    logic [PROD_W-1:0]       rem_reg;
    logic [PROD_W-1:0]       dvs_reg;
    logic [QBITS-1:0]        q_reg;
    logic                    q_bit;
    logic [dbcg_pkg::ROM_AW-1:0] rom_addr;
    logic [GW-1:0]           g_raw;
    logic [GW-1:0]           g_lo;
    logic [GW-1:0]           g_clamped;
    logic [GW-1:0]           gain_reg;
    logic                    wr;

    // classify the request against threshold and dimming state
    assign thr_eff = (cfg.thresh < dbcg_pkg::THRESH_MIN) ? dbcg_pkg::THRESH_MIN : cfg.thresh;
    assign lvl_ext = CW'(s_level);
    assign lvl_nz  = (s_level != '0);
    assign lvl_lt  = (lvl_ext < CW'(thr_eff));

    always_comb begin
        if (cfg.mode_enable && lvl_nz && lvl_lt) begin
            cls_next = dbcg_pkg::CLS_DIM;
        end else if (lvl_nz && dim_active_reg) begin
            cls_next = dbcg_pkg::CLS_LEAVE;
        end else begin
            cls_next = dbcg_pkg::CLS_PASS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_active_reg <= 1'b0;
            cls_reg        <= dbcg_pkg::CLS_PASS;
        end else if (cmd.load) begin
            cls_reg <= cls_next;
            if (cls_next == dbcg_pkg::CLS_DIM) begin
                dim_active_reg <= 1'b1;
            end else if (cls_next == dbcg_pkg::CLS_LEAVE) begin
                dim_active_reg <= 1'b0;
            end
        end
    end

    assign sts.cls = cls_reg;

    // request capture and divider set-up
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            panel_reg <= (cls_next == dbcg_pkg::CLS_DIM) ? thr_eff : TW'(s_level);
            num_reg   <= TW'(lvl_ext - CW'(1));
            mode_reg  <= cfg.mode_enable;
            dvs_reg   <= PROD_W'(thr_eff - TW'(1)) << (QBITS - 1);
            q_reg     <= '0;
        end else if (cmd.div_step) begin
            dvs_reg <= dvs_reg >> 1;
            q_reg   <= (q_reg << 1) | QBITS'(q_bit);
        end
    end

    // restoring divider, one quotient bit per cycle
    assign q_bit = (rem_reg >= dvs_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            rem_reg <= PROD_W'(num_reg) * PROD_W'(TABLE_ENTRIES - 1);
        end else if (cmd.div_step && q_bit) begin
            rem_reg <= rem_reg - dvs_reg;
        end
    end

    // rom lookup and clamp
    assign rom_addr  = (cls_reg == dbcg_pkg::CLS_DIM) ? dbcg_pkg::ROM_AW'(q_reg)
                                                      : dbcg_pkg::ROM_AW'(LAST_ADDR);
    assign g_raw     = GW'(dbcg_pkg::rom_read(rom_addr)) << dbcg_pkg::ROM_SHIFT;
    assign g_lo      = (g_raw < cfg.min_gain) ? cfg.min_gain : g_raw;
    assign g_clamped = (g_lo > cfg.max_gain) ? cfg.max_gain : g_lo;

    always_ff @(posedge aclk) begin
        if (cmd.gain_load) begin
            gain_reg <= g_clamped;
        end
    end

    // result register
    assign wr = (cls_reg != dbcg_pkg::CLS_PASS);

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_panel_level   <= panel_reg;
            m_gain_write    <= wr;
            m_gain_enable   <= (cls_reg == dbcg_pkg::CLS_DIM);
            m_gain_value    <= wr ? gain_reg : '0;
            m_dither_enable <= wr && mode_reg;
            m_dither_depth  <= wr ? dbcg_pkg::depth_of(gain_reg) : '0;
        end
    end

endmodule

// File: hw/rtl/dim_backlight_to_color_gain_core.sv
// dim_backlight_to_color_gain_core: top level of the flicker-free backlight dimming core
// depends on dbcg_pkg, dbcg_cfg, dbcg_ctrl, dbcg_dpath
//
// Usage
//   s_valid/s_ready/s_level carry one requested backlight level per request.
//   m_valid/m_ready carry one result per request: the panel level and, when a
//   gain update is pushed, the colour gain and dither setting (zero otherwise).
//   The apb-style port sets mode, threshold and gain clamps; write it only while
//   no request is in flight. pready is always high.
// Sequencing (accept to m_valid)
//   plain pass-through: decide, done; leaving dimming: decide, gain, done;
//   dimmed level: decide, multiply, one divide step per quotient bit, gain, done;
//   the restoring divider forms the rom index one quotient bit per cycle.
// Throughput
//   one request at a time; s_ready returns once the result has been moved to
//   the output register, so the next request may overlap a result still waiting.
// Reset and stall
//   synchronous active-low reset clears the sequencer, the dimming flag and the
//   output valid flag and restores the register reset values. A stalled receiver
//   holds the result; a finished request then waits before s_ready rises again.
module dim_backlight_to_color_gain_core #(
    parameter int TABLE_ENTRIES = dbcg_pkg::TABLE_ENTRIES_DEF,
    parameter int LEVEL_BITS    = dbcg_pkg::LEVEL_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [LEVEL_BITS-1:0]            s_level,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [dbcg_pkg::THRESH_BITS-1:0] m_panel_level,
    output logic                             m_gain_write,
    output logic                             m_gain_enable,
    output logic [dbcg_pkg::GAIN_BITS-1:0]   m_gain_value,
    output logic                             m_dither_enable,
    output logic [dbcg_pkg::DEPTH_BITS-1:0]  m_dither_depth,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dbcg_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [dbcg_pkg::DATA_BITS-1:0]   pwdata,
    output logic [dbcg_pkg::DATA_BITS-1:0]   prdata,
    output logic                             pready
);

    localparam int QBITS = (TABLE_ENTRIES > 2) ? $clog2(TABLE_ENTRIES) : 1;

    dbcg_pkg::cfg_t cfg;
    dbcg_pkg::cmd_t cmd;
    dbcg_pkg::sts_t sts;

    // configuration registers
    dbcg_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer
    dbcg_ctrl #(
        .QBITS (QBITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath
    dbcg_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .LEVEL_BITS    (LEVEL_BITS),
        .QBITS         (QBITS)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .cmd             (cmd),
        .sts             (sts),
        .s_level         (s_level),
        .m_panel_level   (m_panel_level),
        .m_gain_write    (m_gain_write),
        .m_gain_enable   (m_gain_enable),
        .m_gain_value    (m_gain_value),
        .m_dither_enable (m_dither_enable),
        .m_dither_depth  (m_dither_depth)
    );

    // a result without a gain update carries no gain or dither setting
    a_no_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_gain_write) |-> (m_gain_value == '0 && m_dither_depth == '0
                                        && !m_gain_enable && !m_dither_enable))
        else $error("gain fields set without a gain write");

    // an enabled gain is only ever part of a pushed update
    a_enable_has_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_gain_enable) |-> m_gain_write)
        else $error("gain enable without gain write");

    // one request in flight: no accept in the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous one in flight");

    // dither depth never exceeds its top step
    a_depth_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_dither_depth <= dbcg_pkg::DEPTH_BITS'(dbcg_pkg::MAX_DEPTH)))
        else $error("dither depth out of range");

endmodule
